### src/psf_pkg.sv
// ----------------------------------------------------------------------------
// psf_pkg: shared types and constants for the point-source fringe pixel block
// Payload structs, register map, fixed-point constants, split multiply helpers.
// ----------------------------------------------------------------------------
package psf_pkg;

  localparam int unsigned RowsDefault = 1024;
  localparam int unsigned ColsDefault = 1024;

  localparam int unsigned QW   = 51;   // distance width, 2^-41 m
  localparam int unsigned SumW = 102;  // squared distance width
  localparam int unsigned CsW  = 31;   // Q30 cos/sin magnitude

  localparam logic [63:0] PiQ60    = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] One62    = 64'h4000_0000_0000_0000;
  localparam logic [31:0] FieldMax = 32'h7FFF_FFFF;

  localparam int unsigned SinDiv [6] = '{156, 110, 72, 42, 20, 6};
  localparam int unsigned CosDiv [6] = '{132, 90, 56, 30, 12, 2};

  typedef enum logic [2:0] {
    RegSrcX      = 3'd0,
    RegSrcY      = 3'd1,
    RegAxial     = 3'd2,
    RegAmplitude = 3'd3,
    RegPhase     = 3'd4,
    RegPitchCol  = 3'd5,
    RegPitchRow  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [9:0] row;
    logic [9:0] col;
  } item_t;

  typedef struct packed {
    logic [19:0]        address;
    logic signed [31:0] field_re;
    logic signed [31:0] field_im;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic signed [47:0] src_x;
    logic signed [47:0] src_y;
    logic signed [47:0] axial_distance;
    logic [31:0]        amplitude;
    logic [47:0]        phase_per_length;
    logic [31:0]        pitch_col;
    logic [31:0]        pitch_row;
  } cfg_t;

  typedef struct packed {
    logic [63:0] ll;
    logic [63:0] lh;
    logic [63:0] hl;
    logic [63:0] hh;
  } pp_t;

  typedef struct packed {
    logic [19:0]     addr;
    logic [QW-1:0]   q;
    logic [CsW-1:0]  cr;
    logic [CsW-1:0]  ci;
    logic            nr;
    logic            ni;
  } trig_t;

  // 64x64 product as four 32x32 partial products
  function automatic pp_t pp_mul(input logic [63:0] a, input logic [63:0] b);
    pp_t p;
    p.ll = {32'd0, a[31:0]}  * {32'd0, b[31:0]};
    p.lh = {32'd0, a[31:0]}  * {32'd0, b[63:32]};
    p.hl = {32'd0, a[63:32]} * {32'd0, b[31:0]};
    p.hh = {32'd0, a[63:32]} * {32'd0, b[63:32]};
    return p;
  endfunction

  function automatic logic [127:0] pp_sum(input pp_t p);
    return {64'd0, p.ll} + {32'd0, p.lh, 32'd0} + {32'd0, p.hl, 32'd0} + {p.hh, 64'd0};
  endfunction

endpackage

### src/psf_geom.sv
// ----------------------------------------------------------------------------
// psf_geom: pixel offset and squared distance
// Four stages: offsets, magnitudes, partial squares, sum of squares.
// ----------------------------------------------------------------------------
module psf_geom import psf_pkg::*; #(
  parameter int unsigned ROWS = RowsDefault,
  parameter int unsigned COLS = ColsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  item_t           item_i,
  input  cfg_t            cfg_i,
  output logic            valid_o,
  output logic [19:0]     addr_o,
  output logic [SumW-1:0] sum_o
);

  logic signed [13:0] ry, rx;
  logic signed [46:0] py, px;
  logic [50:0]        d_d [3];
  logic [19:0]        addr_d;

  logic [3:0]  vld_q;
  logic [19:0] addr1_q, addr2_q, addr3_q, addr4_q;
  logic [50:0] d_q [3];
  logic [49:0] a_q [3];
  logic [49:0] hh_q [3];
  logic [49:0] hl_q [3];
  logic [49:0] ll_q [3];
  logic [SumW-1:0] sum_q;

  always_comb begin
    ry = $signed({3'd0, item_i.row, 1'b0}) - $signed(14'(ROWS));
    rx = $signed({3'd0, item_i.col, 1'b0}) - $signed(14'(COLS));
    py = ry * $signed({1'b0, cfg_i.pitch_row});
    px = rx * $signed({1'b0, cfg_i.pitch_col});
    d_d[0] = 51'(py) - {{2{cfg_i.src_y[47]}}, cfg_i.src_y, 1'b0};
    d_d[1] = 51'(px) - {{2{cfg_i.src_x[47]}}, cfg_i.src_x, 1'b0};
    d_d[2] = {{2{cfg_i.axial_distance[47]}}, cfg_i.axial_distance, 1'b0};
    addr_d = 20'(item_i.row) + 20'(item_i.col) * 20'(ROWS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    addr1_q <= addr_d;
    addr2_q <= addr1_q;
    addr3_q <= addr2_q;
    addr4_q <= addr3_q;
    for (int i = 0; i < 3; i++) begin
      d_q[i]  <= d_d[i];
      a_q[i]  <= d_q[i][50] ? 50'(-d_q[i]) : d_q[i][49:0];
      hh_q[i] <= {25'd0, a_q[i][49:25]} * {25'd0, a_q[i][49:25]};
      hl_q[i] <= {25'd0, a_q[i][49:25]} * {25'd0, a_q[i][24:0]};
      ll_q[i] <= {25'd0, a_q[i][24:0]}  * {25'd0, a_q[i][24:0]};
    end
    sum_q <= (SumW'(hh_q[0]) << 50) + (SumW'(hl_q[0]) << 26) + SumW'(ll_q[0])
           + (SumW'(hh_q[1]) << 50) + (SumW'(hl_q[1]) << 26) + SumW'(ll_q[1])
           + (SumW'(hh_q[2]) << 50) + (SumW'(hl_q[2]) << 26) + SumW'(ll_q[2]);
  end

  assign valid_o = vld_q[3];
  assign addr_o  = addr4_q;
  assign sum_o   = sum_q;

endmodule

### src/psf_sqrt.sv
// ----------------------------------------------------------------------------
// psf_sqrt: pipelined integer square root
// One result bit per stage, restoring digit recurrence.
// ----------------------------------------------------------------------------
module psf_sqrt import psf_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [19:0]     addr_i,
  input  logic [SumW-1:0] sum_i,
  output logic            valid_o,
  output logic [19:0]     addr_o,
  output logic [QW-1:0]   q_o
);

  localparam int unsigned RemW = QW + 3;

  logic            vld_q  [QW];
  logic [19:0]     addr_q [QW];
  logic [SumW-1:0] sum_q  [QW];
  logic [RemW-1:0] rem_q  [QW];
  logic [QW-1:0]   root_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int unsigned Pair = QW - 1 - j;
    logic            vin;
    logic [19:0]     ain;
    logic [SumW-1:0] sin;
    logic [RemW-1:0] rin, remx, trial;
    logic [QW-1:0]   qin;

    if (j == 0) begin : g_first
      assign vin = valid_i;
      assign ain = addr_i;
      assign sin = sum_i;
      assign rin = '0;
      assign qin = '0;
    end else begin : g_next
      assign vin = vld_q[j-1];
      assign ain = addr_q[j-1];
      assign sin = sum_q[j-1];
      assign rin = rem_q[j-1];
      assign qin = root_q[j-1];
    end

    always_comb begin
      remx  = {rin[RemW-3:0], sin[2*Pair+1 -: 2]};
      trial = {1'b0, qin, 2'b01};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else begin
        vld_q[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      addr_q[j] <= ain;
      sum_q[j]  <= sin;
      if (remx >= trial) begin
        rem_q[j]  <= remx - trial;
        root_q[j] <= {qin[QW-2:0], 1'b1};
      end else begin
        rem_q[j]  <= remx;
        root_q[j] <= {qin[QW-2:0], 1'b0};
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign addr_o  = addr_q[QW-1];
  assign q_o     = root_q[QW-1];

endmodule

### src/psf_sincos.sv
// ----------------------------------------------------------------------------
// psf_sincos: phase and cos/sin of the phase
// Phase product, octant fold, six Taylor steps with constant divides done as
// reciprocal multiply plus one correction, then quadrant mapping.
// ----------------------------------------------------------------------------
module psf_sincos import psf_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [19:0]   addr_i,
  input  logic [QW-1:0] q_i,
  input  logic [47:0]   ppl_i,
  output logic          valid_o,
  output trig_t         trig_o
);

  localparam int unsigned NSt = 39;
  localparam int unsigned ItFirst = 7;
  localparam int unsigned ItLast = 37;

  typedef struct packed {
    logic [19:0]    addr;
    logic [QW-1:0]  q;
    logic [31:0]    ph;
    logic [1:0]     quad;
    logic           swap;
    logic [29:0]    ra;
    logic [63:0]    x;
    logic [63:0]    x2;
    logic [63:0]    ts;
    logic [63:0]    tc;
    logic [63:0]    fs;
    logic [63:0]    fc;
    pp_t            pa;
    pp_t            pb;
    logic [CsW-1:0] cr;
    logic [CsW-1:0] ci;
    logic           nr;
    logic           ni;
  } sc_t;

  sc_t  sc_in;
  logic vld_q [NSt];
  sc_t  st_q  [NSt];

  always_comb begin
    sc_in      = '0;
    sc_in.addr = addr_i;
    sc_in.q    = q_i;
  end

  for (genvar j = 0; j < NSt; j++) begin : g_st
    sc_t  cur, nxt;
    logic vin;

    if (j == 0) begin : g_first
      assign cur = sc_in;
      assign vin = valid_i;
    end else begin : g_next
      assign cur = st_q[j-1];
      assign vin = vld_q[j-1];
    end

    if (j == 0) begin : g_ph_mul
      always_comb begin
        nxt    = cur;
        nxt.pa = pp_mul({13'd0, cur.q}, {16'd0, ppl_i});
      end
    end else if (j == 1) begin : g_ph_sum
      logic [127:0] s;
      always_comb begin
        s      = pp_sum(cur.pa);
        nxt    = cur;
        nxt.ph = s[64:33];
      end
    end else if (j == 2) begin : g_fold
      always_comb begin
        nxt      = cur;
        nxt.quad = cur.ph[31:30];
        nxt.swap = cur.ph[29:0] > 30'h2000_0000;
        nxt.ra   = nxt.swap ? 30'(31'h4000_0000 - {1'b0, cur.ph[29:0]}) : cur.ph[29:0];
      end
    end else if (j == 3) begin : g_x_mul
      always_comb begin
        nxt    = cur;
        nxt.pa = pp_mul({34'd0, cur.ra}, PiQ60);
      end
    end else if (j == 4) begin : g_x_sum
      logic [127:0] s;
      always_comb begin
        s     = pp_sum(cur.pa);
        nxt   = cur;
        nxt.x = s[92:29];
      end
    end else if (j == 5) begin : g_x2_mul
      always_comb begin
        nxt    = cur;
        nxt.pa = pp_mul(cur.x, cur.x);
      end
    end else if (j == 6) begin : g_x2_sum
      logic [127:0] s;
      always_comb begin
        s      = pp_sum(cur.pa);
        nxt    = cur;
        nxt.x2 = s[125:62];
        nxt.ts = One62;
        nxt.tc = One62;
      end
    end else if (j < ItLast) begin : g_it
      localparam int unsigned K   = (j - ItFirst) / 5;
      localparam int unsigned Ph  = (j - ItFirst) % 5;
      localparam int unsigned Ds  = SinDiv[K];
      localparam int unsigned Dc  = CosDiv[K];
      localparam int unsigned ShS = 62 + $clog2(Ds + 1);
      localparam int unsigned ShC = 62 + $clog2(Dc + 1);
      localparam logic [127:0] RecS = (128'd1 << ShS) / 128'(Ds);
      localparam logic [127:0] RecC = (128'd1 << ShC) / 128'(Dc);

      if (Ph == 0) begin : g_t_mul
        always_comb begin
          nxt    = cur;
          nxt.pa = pp_mul(cur.x2, cur.ts);
          nxt.pb = pp_mul(cur.x2, cur.tc);
        end
      end else if (Ph == 1) begin : g_t_sum
        logic [127:0] s, c;
        always_comb begin
          s      = pp_sum(cur.pa);
          c      = pp_sum(cur.pb);
          nxt    = cur;
          nxt.fs = s[125:62];
          nxt.fc = c[125:62];
        end
      end else if (Ph == 2) begin : g_r_mul
        always_comb begin
          nxt    = cur;
          nxt.pa = pp_mul(cur.fs, RecS[63:0]);
          nxt.pb = pp_mul(cur.fc, RecC[63:0]);
        end
      end else if (Ph == 3) begin : g_r_sum
        logic [127:0] s, c;
        always_comb begin
          s      = pp_sum(cur.pa);
          c      = pp_sum(cur.pb);
          nxt    = cur;
          nxt.ts = 64'(s >> ShS);
          nxt.tc = 64'(c >> ShC);
        end
      end else begin : g_fix
        logic [63:0] rs, rc, qs, qc;
        always_comb begin
          rs     = cur.fs - cur.ts * 64'(Ds);
          rc     = cur.fc - cur.tc * 64'(Dc);
          qs     = cur.ts + {63'd0, rs >= 64'(Ds)};
          qc     = cur.tc + {63'd0, rc >= 64'(Dc)};
          nxt    = cur;
          nxt.ts = One62 - qs;
          nxt.tc = One62 - qc;
        end
      end
    end else if (j == ItLast) begin : g_s_mul
      always_comb begin
        nxt    = cur;
        nxt.pa = pp_mul(cur.x, cur.ts);
      end
    end else begin : g_out
      logic [127:0]   s;
      logic [63:0]    sr, cc;
      logic [CsW-1:0] sv, cv, sa, ca;
      always_comb begin
        s  = pp_sum(cur.pa);
        sr = s[125:62] + 64'h8000_0000;
        cc = cur.tc + 64'h8000_0000;
        sv = sr[32+CsW-1:32];
        cv = cc[32+CsW-1:32];
        sa = cur.swap ? cv : sv;
        ca = cur.swap ? sv : cv;
        nxt = cur;
        case (cur.quad)
          2'd0: begin
            nxt.cr = ca; nxt.nr = 1'b0; nxt.ci = sa; nxt.ni = 1'b0;
          end
          2'd1: begin
            nxt.cr = sa; nxt.nr = 1'b1; nxt.ci = ca; nxt.ni = 1'b0;
          end
          2'd2: begin
            nxt.cr = ca; nxt.nr = 1'b1; nxt.ci = sa; nxt.ni = 1'b1;
          end
          default: begin
            nxt.cr = sa; nxt.nr = 1'b0; nxt.ci = ca; nxt.ni = 1'b1;
          end
        endcase
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else begin
        vld_q[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[j] <= nxt;
    end
  end

  assign valid_o     = vld_q[NSt-1];
  assign trig_o.addr = st_q[NSt-1].addr;
  assign trig_o.q    = st_q[NSt-1].q;
  assign trig_o.cr   = st_q[NSt-1].cr;
  assign trig_o.ci   = st_q[NSt-1].ci;
  assign trig_o.nr   = st_q[NSt-1].nr;
  assign trig_o.ni   = st_q[NSt-1].ni;

endmodule

### src/psf_div.sv
// ----------------------------------------------------------------------------
// psf_div: amplitude scaling and division by distance
// Scale, range check, 31 restoring divide stages, sign and saturation.
// ----------------------------------------------------------------------------
module psf_div import psf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  trig_t       trig_i,
  input  logic [31:0] amp_i,
  output logic        valid_o,
  output result_t     result_o
);

  localparam int unsigned NSt = 34;

  typedef struct packed {
    logic [19:0]   addr;
    logic [QW-1:0] q;
    logic          nr;
    logic          ni;
    logic          qz;
    logic [62:0]   mr;
    logic [62:0]   mi;
    logic [30:0]   nlr;
    logic [30:0]   nli;
    logic [QW:0]   remr;
    logic [QW:0]   remi;
    logic [30:0]   quor;
    logic [30:0]   quoi;
    logic          clr;
    logic          cli;
    result_t       res;
  } dv_t;

  dv_t  dv_in;
  logic vld_q [NSt];
  dv_t  st_q  [NSt];

  always_comb begin
    dv_in      = '0;
    dv_in.addr = trig_i.addr;
    dv_in.q    = trig_i.q;
    dv_in.nr   = trig_i.nr;
    dv_in.ni   = trig_i.ni;
    dv_in.mr   = 63'(amp_i) * 63'(trig_i.cr);
    dv_in.mi   = 63'(amp_i) * 63'(trig_i.ci);
  end

  for (genvar j = 0; j < NSt; j++) begin : g_st
    dv_t  cur, nxt;
    logic vin;

    if (j == 0) begin : g_first
      assign cur = dv_in;
      assign vin = valid_i;
    end else begin : g_next
      assign cur = st_q[j-1];
      assign vin = vld_q[j-1];
    end

    if (j == 0) begin : g_scale
      assign nxt = cur;
    end else if (j == 1) begin : g_range
      logic [81:0] numr, numi, lim;
      always_comb begin
        numr = {8'd0, cur.mr, 11'd0};
        numi = {8'd0, cur.mi, 11'd0};
        lim  = {cur.q, 31'd0};
        nxt      = cur;
        nxt.qz   = cur.q == '0;
        nxt.clr  = numr >= lim;
        nxt.cli  = numi >= lim;
        nxt.nlr  = numr[30:0];
        nxt.nli  = numi[30:0];
        nxt.remr = nxt.clr ? '0 : (QW+1)'(numr >> 31);
        nxt.remi = nxt.cli ? '0 : (QW+1)'(numi >> 31);
        nxt.quor = '0;
        nxt.quoi = '0;
      end
    end else if (j < NSt - 1) begin : g_bit
      localparam int unsigned B = 32 - j;
      logic [QW:0] xr, xi;
      always_comb begin
        xr  = {cur.remr[QW-1:0], cur.nlr[B]};
        xi  = {cur.remi[QW-1:0], cur.nli[B]};
        nxt = cur;
        if (xr >= {1'b0, cur.q}) begin
          nxt.remr    = xr - {1'b0, cur.q};
          nxt.quor[B] = 1'b1;
        end else begin
          nxt.remr = xr;
        end
        if (xi >= {1'b0, cur.q}) begin
          nxt.remi    = xi - {1'b0, cur.q};
          nxt.quoi[B] = 1'b1;
        end else begin
          nxt.remi = xi;
        end
      end
    end else begin : g_out
      logic [31:0] magr, magi;
      always_comb begin
        magr = cur.clr ? FieldMax : {1'b0, cur.quor};
        magi = cur.cli ? FieldMax : {1'b0, cur.quoi};
        nxt  = cur;
        nxt.res.address = cur.addr;
        if (cur.qz) begin
          nxt.res.field_re  = FieldMax;
          nxt.res.field_im  = '0;
          nxt.res.saturated = 1'b1;
        end else begin
          nxt.res.field_re  = cur.nr ? -magr : magr;
          nxt.res.field_im  = cur.ni ? -magi : magi;
          nxt.res.saturated = cur.clr | cur.cli;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else begin
        vld_q[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[j] <= nxt;
    end
  end

  assign valid_o  = vld_q[NSt-1];
  assign result_o = st_q[NSt-1].res;

endmodule

### src/point_source_fringe_pixel_top.sv
// ----------------------------------------------------------------------------
// point_source_fringe_pixel_top: point-source fringe pixel generator
// Takes one pixel per clock and returns its complex field and store address
// in input order. busy is never raised, so start may be held high every cycle;
// each result appears for one cycle with result_valid_o and must be taken
// then. The latency is set by the pipeline depth: 4 geometry stages, 51 square
// root stages (one bit each), 39 phase and cos/sin stages and 34 scale and
// divide stages (one quotient bit per divide stage).
// ----------------------------------------------------------------------------
module point_source_fringe_pixel_top import psf_pkg::*; #(
  parameter int unsigned ROWS = RowsDefault,
  parameter int unsigned COLS = ColsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  item_t       item_i,
  output logic        result_valid_o,
  output result_t     result_o
);

  localparam cfg_t CfgReset = '{
    src_x:            '0,
    src_y:            '0,
    axial_distance:   '0,
    amplitude:        32'h0001_0000,
    phase_per_length: '0,
    pitch_col:        '0,
    pitch_row:        '0
  };

  cfg_t            cfg_q;
  logic            wr_en;
  logic            g_valid;
  logic [19:0]     g_addr;
  logic [SumW-1:0] g_sum;
  logic            s_valid;
  logic [19:0]     s_addr;
  logic [QW-1:0]   s_q;
  logic            t_valid;
  trig_t           t_trig;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (wr_en) begin
      unique case (reg_idx_e'(paddr[5:3]))
        RegSrcX:      cfg_q.src_x            <= pwdata[47:0];
        RegSrcY:      cfg_q.src_y            <= pwdata[47:0];
        RegAxial:     cfg_q.axial_distance   <= pwdata[47:0];
        RegAmplitude: cfg_q.amplitude        <= pwdata[31:0];
        RegPhase:     cfg_q.phase_per_length <= pwdata[47:0];
        RegPitchCol:  cfg_q.pitch_col        <= pwdata[31:0];
        RegPitchRow:  cfg_q.pitch_row        <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[5:3]))
      RegSrcX:      prdata = {16'd0, cfg_q.src_x};
      RegSrcY:      prdata = {16'd0, cfg_q.src_y};
      RegAxial:     prdata = {16'd0, cfg_q.axial_distance};
      RegAmplitude: prdata = {32'd0, cfg_q.amplitude};
      RegPhase:     prdata = {16'd0, cfg_q.phase_per_length};
      RegPitchCol:  prdata = {32'd0, cfg_q.pitch_col};
      RegPitchRow:  prdata = {32'd0, cfg_q.pitch_row};
      default:      prdata = '0;
    endcase
  end

  psf_geom #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .item_i  (item_i),
    .cfg_i   (cfg_q),
    .valid_o (g_valid),
    .addr_o  (g_addr),
    .sum_o   (g_sum)
  );

  psf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (g_valid),
    .addr_i  (g_addr),
    .sum_i   (g_sum),
    .valid_o (s_valid),
    .addr_o  (s_addr),
    .q_o     (s_q)
  );

  psf_sincos u_sincos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_valid),
    .addr_i  (s_addr),
    .q_i     (s_q),
    .ppl_i   (cfg_q.phase_per_length),
    .valid_o (t_valid),
    .trig_o  (t_trig)
  );

  psf_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (t_valid),
    .trig_i   (t_trig),
    .amp_i    (cfg_q.amplitude),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );

endmodule

### test/point_source_fringe_pixel_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_source_fringe_pixel_top_tb: self-checking bench for the fringe pixel
// Drives pixel transfers with random gaps and programs the registers over the
// APB port between phases. Each pixel's field is computed here in fixed point
// and compared field by field with the result stream, oldest first.
// ----------------------------------------------------------------------------
module point_source_fringe_pixel_top_tb;
  import psf_pkg::*;

  localparam int unsigned Rows     = 1024;
  localparam int unsigned Cols     = 1024;
  localparam int unsigned Latency  = 128;
  localparam int unsigned Watchdog = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  item_t       item_i = '0;
  logic        result_valid_o;
  result_t     result_o;

  cfg_t        cfg;
  result_t     fields_due[$];
  int          errors = 0;
  int          quiet_cycles = 0;
  bit          no_gaps = 1'b0;

  point_source_fringe_pixel_top u_top (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .item_i, .result_valid_o, .result_o
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // sin and cos (Q30) of r turns/2^32, r within the first octant
  task automatic octant_trig(input logic [63:0] r, output logic [63:0] s,
                             output logic [63:0] c);
    logic [127:0] tp;
    logic [63:0]  x, x2, ts, tc;
    tp = {64'd0, r} * {64'd0, PiQ60};
    x  = tp[92:29];
    x2 = q62_mul(x, x);
    ts = One62;
    tc = One62;
    for (int k = 0; k < 6; k++) begin
      ts = One62 - q62_mul(x2, ts) / 64'(SinDiv[k]);
      tc = One62 - q62_mul(x2, tc) / 64'(CosDiv[k]);
    end
    ts = q62_mul(x, ts);
    s = (ts + 64'h8000_0000) >> 32;
    c = (tc + 64'h8000_0000) >> 32;
  endtask

  task automatic scale_part(input logic [63:0] c, input logic [63:0] q,
                            input bit neg, output logic [31:0] v, inout bit clip);
    logic [127:0] num, mag;
    num = ({64'd0, 32'd0, cfg.amplitude} * {64'd0, c}) << 11;
    if (({64'd0, q} << 31) <= num) begin
      clip = 1'b1;
      mag = {96'd0, FieldMax};
    end else begin
      mag = num / {64'd0, q};
    end
    v = neg ? 32'(0 - mag[31:0]) : mag[31:0];
  endtask

  task automatic predict_field(input item_t px, output result_t f);
    longint       dy, dx, dz;
    logic [63:0]  ay, ax, az, q, t, r, sa, ca, cr, ci;
    logic [127:0] sq, ph;
    logic [31:0]  p;
    bit           nr, ni, clip;
    dy = (2 * longint'(px.row) - longint'(Rows)) * longint'({32'd0, cfg.pitch_row})
         - 2 * longint'(cfg.src_y);
    dx = (2 * longint'(px.col) - longint'(Cols)) * longint'({32'd0, cfg.pitch_col})
         - 2 * longint'(cfg.src_x);
    dz = 2 * longint'(cfg.axial_distance);
    ay = dy < 0 ? -dy : dy;
    ax = dx < 0 ? -dx : dx;
    az = dz < 0 ? -dz : dz;
    sq = {64'd0, ay} * {64'd0, ay} + {64'd0, ax} * {64'd0, ax} + {64'd0, az} * {64'd0, az};
    q = '0;
    for (int b = 51; b >= 0; b--) begin
      t = q | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= sq) q = t;
    end
    f.address = 20'(px.row + px.col * Rows);
    clip = 1'b0;
    if (q == 0) begin
      f.field_re = FieldMax;
      f.field_im = '0;
      f.saturated = 1'b1;
      return;
    end
    ph = {64'd0, q} * {80'd0, cfg.phase_per_length};
    p = ph[64:33];
    r = {34'd0, p[29:0]};
    if (r <= 64'h2000_0000) octant_trig(r, sa, ca);
    else octant_trig(64'h4000_0000 - r, ca, sa);
    case (p[31:30])
      2'd0: begin cr = ca; nr = 0; ci = sa; ni = 0; end
      2'd1: begin cr = sa; nr = 1; ci = ca; ni = 0; end
      2'd2: begin cr = ca; nr = 1; ci = sa; ni = 1; end
      default: begin cr = sa; nr = 0; ci = ca; ni = 1; end
    endcase
    scale_part(cr, q, nr, f.field_re, clip);
    scale_part(ci, q, ni, f.field_im, clip);
    f.saturated = clip;
  endtask

  task automatic wait_drain();
    while (fields_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 6'(8 * int'(idx));
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      RegSrcX:      cfg.src_x = val[47:0];
      RegSrcY:      cfg.src_y = val[47:0];
      RegAxial:     cfg.axial_distance = val[47:0];
      RegAmplitude: cfg.amplitude = val[31:0];
      RegPhase:     cfg.phase_per_length = val[47:0];
      RegPitchCol:  cfg.pitch_col = val[31:0];
      default:      cfg.pitch_row = val[31:0];
    endcase
  endtask

  task automatic program_all(input logic [47:0] sx, input logic [47:0] sy,
                             input logic [47:0] az, input logic [31:0] amp,
                             input logic [47:0] ppl, input logic [31:0] pc,
                             input logic [31:0] pr);
    start <= 1'b0;
    wait_drain();
    write_reg(RegSrcX, {16'd0, sx});
    write_reg(RegSrcY, {16'd0, sy});
    write_reg(RegAxial, {16'd0, az});
    write_reg(RegAmplitude, {32'd0, amp});
    write_reg(RegPhase, {16'd0, ppl});
    write_reg(RegPitchCol, {32'd0, pc});
    write_reg(RegPitchRow, {32'd0, pr});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_pixel(input logic [9:0] row, input logic [9:0] col);
    int      gap;
    item_t   px;
    result_t f;
    gap = no_gaps ? 0 : ($urandom_range(0, 9) < 6 ? 0 :
          ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(10, 60)));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    px.row = row;
    px.col = col;
    start  <= 1'b1;
    item_i <= px;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_field(px, f);
    fields_due.push_back(f);
  endtask

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) send_pixel(10'($urandom), 10'($urandom));
  endtask

  function automatic logic [47:0] pick48();
    case ($urandom_range(0, 5))
      0: return 48'h7FFF_FFFF_FFFF;
      1: return 48'h8000_0000_0000;
      2: return '0;
      3: return 48'({$urandom, $urandom});
      default: return 48'($signed(32'($urandom_range(0, 2**20)) - 32'sd524288) * 64);
    endcase
  endfunction

  task automatic test_reset_state();
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd512, 10'd512);
  endtask

  task automatic test_directed();
    program_all(48'd0, 48'd0, 48'd1 << 30, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'h155, 10'h2AA);
    program_all(48'd0, 48'd0, 48'd0, 32'd65536, 48'd1 << 20, 32'd1 << 20, 32'd1 << 20);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd513, 10'd512);
    send_pixel(10'd0, 10'd512);
    program_all(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 32'd0,
                48'd0, 32'd0, 32'd0);
    send_pixel(10'd3, 10'd7);
    send_pixel(10'd1023, 10'd0);
    program_all(48'd1000, 48'h7FFF_FFFF_FFFF, 48'd12345, 32'h0001_0000,
                48'hAAAA_5555_AAAA, 32'd4096, 32'd77);
    send_pixel(10'd2, 10'd600);
    send_pixel(10'd900, 10'd11);
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 30; ph++) begin
      no_gaps = (ph % 5 == 2);
      program_all(pick48(), pick48(), pick48(),
                  $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom,
                  $urandom_range(0, 4) == 0 ? 48'hFFFF_FFFF_FFFF : 48'({$urandom, $urandom}),
                  $urandom_range(0, 4) == 0 ? 32'hFFFF_FFFF : $urandom_range(0, 1 << 24),
                  $urandom_range(0, 4) == 0 ? 32'hFFFF_FFFF : $urandom_range(0, 1 << 24));
      send_random(50);
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_drain_pause();
    send_random(10);
    start <= 1'b0;
    wait_drain();
    send_random(10);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (fields_due.size() == 0) begin
        $error("result with none pending: address %0h", result_o.address);
        errors++;
      end else begin
        result_t f;
        f = fields_due.pop_front();
        if (result_o.address !== f.address) begin
          $error("address exp %0h got %0h", f.address, result_o.address); errors++;
        end
        if (result_o.field_re !== f.field_re) begin
          $error("field_re exp %0h got %0h", f.field_re, result_o.field_re); errors++;
        end
        if (result_o.field_im !== f.field_im) begin
          $error("field_im exp %0h got %0h", f.field_im, result_o.field_im); errors++;
        end
        if (result_o.saturated !== f.saturated) begin
          $error("saturated exp %0b got %0b", f.saturated, result_o.saturated); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > Watchdog) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    cfg = '0;
    cfg.amplitude = 32'd65536;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed();
    test_drain_pause();
    test_random_phases();
    start <= 1'b0;
    wait_drain();
    repeat (Latency + 20) @(posedge clk_i);
    if (errors == 0 && fields_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
